// ----- rtl/core/planar_text_vram_masked_access_macros.svh -----
// Assertion helpers for the text VRAM block
`ifndef PLANAR_TEXT_VRAM_MASKED_ACCESS_MACROS_SVH
`define PLANAR_TEXT_VRAM_MASKED_ACCESS_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PTV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text vram assertion failed");
// next-cycle implication
`define PTV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text vram assertion failed");
`else
`define PTV_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PTV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/ptvram_pkg.sv -----
`timescale 1ns / 1ps

package ptvram_pkg;

    localparam int ADDR_W              = 19;
    localparam int DATA_W              = 16;
    localparam int SEL_W               = 5;
    localparam int MAX_PLANES          = 4;
    localparam int PLANE_ADDR_BITS_DEF = 17;
    localparam int PLANE_COUNT_DEF     = 4;
    localparam int CFG_IDX_W           = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_MASK   = 2'd1;

    typedef struct packed {
        logic              action;
        logic              is_word;
        logic [ADDR_W-1:0] byte_address;
        logic [DATA_W-1:0] write_data;
    } ptv_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              content_changed;
        logic              insert_wait;
    } ptv_rsp_t;

    // Plane number modulo count (count 1..4). Mod 3 uses base-4 digit sums.
    function automatic logic [1:0] plane_wrap(input logic [19:0] hi, input int count);
        logic [4:0] s;
        logic [3:0] t;
        logic [1:0] m;
        s = '0;
        for (int i = 0; i < 10; i++)
        begin
            s = s + 5'(hi[2*i +: 2]);
        end
        t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[4]);
        if (t >= 4'd6)
        begin
            t = t - 4'd6;
        end
        else if (t >= 4'd3)
        begin
            t = t - 4'd3;
        end
        m = 2'(count - 1);
        return (count == 3) ? t[1:0] : (hi[1:0] & m);
    endfunction

endpackage

// ----- rtl/core/ptvram_ram.sv -----
`timescale 1ns / 1ps

module ptvram_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/planar_text_vram_masked_access.sv -----
`timescale 1ns / 1ps
// The result strobe (done) is registered from the S_MOD state that a taken start enters.
// A new start is taken only after the previous transaction is through (plane RAM read, then merge and write back).
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset: after rst_n the plane RAMs are zeroed one word per cycle, all planes at once,
// sweeping all 2^(PLANE_ADDR_BITS-1) words with busy high; config writes are taken throughout.
`include "planar_text_vram_masked_access_macros.svh"

module planar_text_vram_masked_access #(
    parameter int PLANE_ADDR_BITS = ptvram_pkg::PLANE_ADDR_BITS_DEF,
    parameter int PLANE_COUNT     = ptvram_pkg::PLANE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  ptvram_pkg::ptv_cmd_t           cmd,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ptvram_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptvram_pkg::DATA_W-1:0]  cfg_data,
    output logic                           done,
    output ptvram_pkg::ptv_rsp_t           result
);

    import ptvram_pkg::*;

    localparam int WORD_W = PLANE_ADDR_BITS - 1;
    localparam int WORDS  = 1 << WORD_W;
    localparam int PIDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    // sequencer codes
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_MOD   = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [WORD_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]        phase_reg;
    logic [SEL_W-1:0]  plane_select_reg;
    logic [DATA_W-1:0] write_mask_reg;
    ptv_cmd_t          cmd_reg;
    logic [WORD_W-1:0] widx_reg;
    logic [PIDX_W-1:0] plane_reg;
    logic              done_reg;
    ptv_rsp_t          rsp_reg, rsp_next;

    logic              accept;
    logic [31:0]       addr_ext;
    logic [31:0]       addr_hi;
    logic [WORD_W-1:0] in_widx;
    logic [PIDX_W-1:0] in_plane;
    logic [WORD_W-1:0] waddr;
    logic [DATA_W-1:0] lane, dpos, keep;
    logic [DATA_W-1:0] rd_word;
    logic [DATA_W-1:0] ram_rdata [PLANE_COUNT];
    logic [DATA_W-1:0] merged    [PLANE_COUNT];
    logic [PLANE_COUNT-1:0] plane_we;
    logic              clearing;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = rsp_reg;
    assign clearing  = (state_reg == S_CLEAR);

    // address split of the incoming transaction
    assign addr_ext = 32'(cmd.byte_address);
    assign addr_hi  = addr_ext >> PLANE_ADDR_BITS;
    assign in_widx  = addr_ext[PLANE_ADDR_BITS-1:1];
    assign in_plane = PIDX_W'(plane_wrap(addr_hi[19:0], PLANE_COUNT));

    // write address: clear sweep or write-back of the held transaction
    assign waddr = clearing ? clr_cnt_reg : widx_reg;

    // byte lane and positioned data
    always_comb
    begin
        if (cmd_reg.is_word)
        begin
            lane = 16'hFFFF;
            dpos = cmd_reg.write_data;
        end
        else if (cmd_reg.byte_address[0])
        begin
            lane = 16'h00FF;
            dpos = {8'h00, cmd_reg.write_data[7:0]};
        end
        else
        begin
            lane = 16'hFF00;
            dpos = {cmd_reg.write_data[7:0], 8'h00};
        end
        keep = write_mask_reg | ~lane;
    end

    // one RAM per plane; a multi-plane write hits them all in the same cycle
    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_plane
        logic sel;
        logic [DATA_W-1:0] wdata;

        assign sel = (plane_select_reg != '0) ? plane_select_reg[p]
                                              : (plane_reg == PIDX_W'(p));
        assign merged[p] = (ram_rdata[p] & keep) | (dpos & ~keep);
        assign plane_we[p] = (state_reg == S_MOD) && cmd_reg.action && sel
                             && (merged[p] != ram_rdata[p]);
        assign wdata = clearing ? '0 : merged[p];

        ptvram_ram #(
            .WIDTH (DATA_W),
            .DEPTH (WORDS)
        ) u_ram (
            .clk   (clk),
            .we    (clearing || plane_we[p]),
            .waddr (waddr),
            .wdata (wdata),
            .raddr (in_widx),
            .rdata (ram_rdata[p])
        );
    end

    // result formatting
    assign rd_word = ram_rdata[plane_reg];

    always_comb
    begin
        rsp_next.insert_wait     = (phase_reg != 2'd0);
        rsp_next.content_changed = |plane_we;
        if (cmd_reg.action)
        begin
            rsp_next.read_data = '0;
        end
        else if (cmd_reg.is_word)
        begin
            rsp_next.read_data = rd_word;
        end
        else if (cmd_reg.byte_address[0])
        begin
            rsp_next.read_data = {8'h00, rd_word[7:0]};
        end
        else
        begin
            rsp_next.read_data = {8'h00, rd_word[15:8]};
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + WORD_W'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            phase_reg        <= '0;
            plane_select_reg <= '0;
            write_mask_reg   <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= (state_reg == S_MOD);
            if (accept)
            begin
                phase_reg <= phase_reg + 2'd1;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PLANE_SELECT)
                begin
                    plane_select_reg <= cfg_data[SEL_W-1:0];
                end
                else if (cfg_index == REG_WRITE_MASK)
                begin
                    write_mask_reg <= cfg_data;
                end
            end
        end
    end

    // transaction and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            widx_reg  <= in_widx;
            plane_reg <= in_plane;
        end
        if (state_reg == S_MOD)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // checks
    `PTV_ASSERT_NEXT(a_accept_to_mod, clk, rst_n, accept, state_reg == S_MOD)
    `PTV_ASSERT_NEXT(a_mod_to_done, clk, rst_n, state_reg == S_MOD, done)
    `PTV_ASSERT_NOW(a_no_done_in_clear, clk, rst_n, clearing, !done)
    `PTV_ASSERT_NOW(a_read_no_change, clk, rst_n, done && !cmd_reg.action, !result.content_changed)
    `PTV_ASSERT_NOW(a_write_no_data, clk, rst_n, done && cmd_reg.action, result.read_data == '0)

endmodule
